// ----- hw/rtl/mctb_pkg.sv -----
// ----------------------------------------------------------------------------
// mctb_pkg
// Shared types and constants of the millisecond timer bank: command and
// result codes, field widths, controller states and default sizes.
// ----------------------------------------------------------------------------
package mctb_pkg;

	localparam int unsigned NUM_TIMERS_DEF = 16;
	localparam int unsigned TIME_WIDTH_DEF = 32;
	localparam int unsigned MAX_RESULTS    = 16;

	localparam int unsigned FUNC_W = 3;
	localparam int unsigned ID_W   = 4;
	localparam int unsigned DUR_W  = 32;
	localparam int unsigned KIND_W = 2;
	localparam int unsigned REM_W  = 32;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_TICK   = 3'd0,
		FUNC_START  = 3'd1,
		FUNC_CANCEL = 3'd2,
		FUNC_PAUSE  = 3'd3,
		FUNC_RESUME = 3'd4,
		FUNC_QUERY  = 3'd5
	} func_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_EXPIRED = 2'd0,
		KIND_QUERY   = 2'd1,
		KIND_ACK     = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_SCAN = 2'd1,
		ST_CMD  = 2'd2
	} state_t;

endpackage

// ----- hw/rtl/mctb_if.sv -----
// ----------------------------------------------------------------------------
// mctb_if
// Valid/ready channels of the timer bank: command items in, result items out.
// ----------------------------------------------------------------------------
interface mctb_in_if;
	logic                          valid;
	logic                          ready;
	logic [mctb_pkg::FUNC_W-1:0]   func;
	logic [mctb_pkg::ID_W-1:0]     timer_id;
	logic [mctb_pkg::DUR_W-1:0]    duration_ms;
	logic                          repeat_mode;

	modport source (output valid, output func, output timer_id, output duration_ms,
		output repeat_mode, input ready);
	modport sink (input valid, input func, input timer_id, input duration_ms,
		input repeat_mode, output ready);
endinterface

interface mctb_out_if;
	logic                               valid;
	logic                               ready;
	logic [mctb_pkg::KIND_W-1:0]        kind;
	logic [mctb_pkg::ID_W-1:0]          which_timer;
	logic signed [mctb_pkg::REM_W-1:0]  remaining_ms;
	logic                               is_running;
	logic                               is_paused;
	logic                               last;

	modport source (output valid, output kind, output which_timer, output remaining_ms,
		output is_running, output is_paused, output last, input ready);
	modport sink (input valid, input kind, input which_timer, input remaining_ms,
		input is_running, input is_paused, input last, output ready);
endinterface

// ----- hw/rtl/multi_channel_ms_timer_bank_top.sv -----
// ----------------------------------------------------------------------------
// multi_channel_ms_timer_bank_top
// Bank of millisecond timers sharing one counter, with start, cancel, pause,
// resume and query commands and a tick command that scans all timers.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries command items (valid/ready), rsp carries result items.
//   Deadline and period of every timer live in one memory with a registered
//   read port; active, paused and repeat flags are flip-flops.
//   Start, cancel, pause, resume and query: one result item; the entry is read,
//   then modified and written back, and cmd is ready again once rsp is free.
//   Tick: bumps the counter and streams the timers through a read pipeline,
//   one entry a cycle while rsp takes the expiries; cmd is ready again once
//   the scan has ended and the final expiry has gone to the result register.
//   Expired results pass through a one-entry holding register so that the
//   final one can carry last; a tick with nothing due gives no item.
//   A tick gives at most MAX_RESULTS expired items; later due timers fire on
//   a following tick. Unknown commands are taken and give no item.
//   A stalled rsp stops the scan in place; the result register holds until
//   taken and cmd is still accepted meanwhile when the bank is idle.
//   Reset clears the counter and all flags; the memory needs no clearing,
//   since an inactive timer never reads its entry.
// ----------------------------------------------------------------------------
module multi_channel_ms_timer_bank_top #(
	parameter int unsigned NUM_TIMERS = mctb_pkg::NUM_TIMERS_DEF,
	parameter int unsigned TIME_WIDTH = mctb_pkg::TIME_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	mctb_in_if.sink     cmd,
	mctb_out_if.source  rsp
);
	import mctb_pkg::*;

	localparam int unsigned IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int unsigned ISS_W = $clog2(NUM_TIMERS + 1);
	localparam int unsigned CNT_W = $clog2(MAX_RESULTS + 1);
	localparam int unsigned EXT_W = IDX_W + ID_W;
	localparam int unsigned TW    = TIME_WIDTH;

	typedef logic [TW-1:0] tval_t;

	// state and flags
	state_t                  state_q, state_d;
	tval_t                   now_q;
	logic [NUM_TIMERS-1:0]   act_q, pau_q, rep_q;

	// memory
	logic [2*TW-1:0]         mem [NUM_TIMERS];
	logic [2*TW-1:0]         mem_rd_q;
	logic                    rd_en, wr_en;
	logic [IDX_W-1:0]        rd_addr, wr_addr;
	logic [2*TW-1:0]         wr_data;
	tval_t                   dl_rd, per_rd;

	// scan
	logic [ISS_W-1:0]        iss_q;
	logic                    v_s1;
	logic [IDX_W-1:0]        idx_s1;
	logic [CNT_W-1:0]        cnt_q;
	logic                    pend_v_q, pend_run_q;
	logic [IDX_W-1:0]        pend_idx_q;
	logic [EXT_W-1:0]        pend_ext;
	tval_t                   due_diff, scan_sum;
	logic                    iss_done, fire, stall, adv, scan_end, finish, drain;

	// command
	func_t                   cf_q;
	logic [ID_W-1:0]         cid_q;
	tval_t                   cdur_q;
	logic                    crep_q, cok_q;
	logic [EXT_W-1:0]        cid_ext;
	logic [IDX_W-1:0]        cidx;
	logic                    act_o, pau_o, act_n, pau_n, rep_n, c_wen, cmd_done;
	tval_t                   diff_c, add_c, w_dl, w_per, rem_src;
	logic [REM_W-1:0]        rem_cl;

	// input decode
	func_t                   in_func;
	logic [EXT_W-1:0]        in_ext;
	logic [IDX_W-1:0]        in_idx;
	logic                    in_ok, cmd_acc;

	// output register
	logic                    out_v_q, out_free, out_load;
	kind_t                   out_kind_q;
	logic [ID_W-1:0]         out_id_q;
	logic [REM_W-1:0]        out_rem_q;
	logic                    out_run_q, out_pau_q, out_last_q;

	assign in_func  = func_t'(cmd.func);
	assign in_ext   = EXT_W'(cmd.timer_id);
	assign in_idx   = in_ext[IDX_W-1:0];
	assign in_ok    = (32'(cmd.timer_id) < NUM_TIMERS);
	assign cmd_acc  = cmd.valid && cmd.ready;
	assign out_free = !out_v_q || rsp.ready;

	assign dl_rd  = mem_rd_q[2*TW-1:TW];
	assign per_rd = mem_rd_q[TW-1:0];

	// scan evaluation
	assign iss_done = (iss_q == ISS_W'(NUM_TIMERS));
	assign due_diff = now_q - dl_rd;
	assign scan_sum = dl_rd + per_rd;
	assign fire     = (state_q == ST_SCAN) && v_s1 && act_q[idx_s1] && !pau_q[idx_s1]
		&& !due_diff[TW-1] && (cnt_q < CNT_W'(MAX_RESULTS));
	assign stall    = fire && pend_v_q && !out_free;
	assign adv      = !stall;
	assign scan_end = (state_q == ST_SCAN) && iss_done && !v_s1;
	assign finish   = scan_end && (!pend_v_q || out_free);
	assign drain    = scan_end && pend_v_q && out_free;
	assign pend_ext = EXT_W'(pend_idx_q);

	// command evaluation
	assign cid_ext  = EXT_W'(cid_q);
	assign cidx     = cid_ext[IDX_W-1:0];
	assign act_o    = act_q[cidx];
	assign pau_o    = pau_q[cidx];
	assign diff_c   = dl_rd - now_q;
	assign add_c    = now_q + ((cf_q == FUNC_START) ? cdur_q : dl_rd);
	assign cmd_done = (state_q == ST_CMD) && out_free;

	always_comb begin
		act_n   = act_o;
		pau_n   = pau_o;
		rep_n   = rep_q[cidx];
		w_dl    = dl_rd;
		w_per   = per_rd;
		c_wen   = 1'b0;
		rem_src = pau_o ? dl_rd : diff_c;
		unique case (cf_q)
			FUNC_START: begin
				act_n   = 1'b1;
				pau_n   = 1'b0;
				rep_n   = crep_q;
				w_dl    = add_c;
				w_per   = cdur_q;
				c_wen   = 1'b1;
				rem_src = cdur_q;
			end
			FUNC_CANCEL: begin
				act_n = 1'b0;
				pau_n = 1'b0;
				rep_n = 1'b0;
				w_dl  = '0;
				w_per = '0;
				c_wen = 1'b1;
			end
			FUNC_PAUSE: begin
				if (act_o && !pau_o) begin
					w_dl  = diff_c;
					pau_n = 1'b1;
					c_wen = 1'b1;
				end
			end
			FUNC_RESUME: begin
				if (act_o && pau_o) begin
					w_dl  = add_c;
					pau_n = 1'b0;
					c_wen = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// saturation of the time difference to the result width
	generate
		if (TW > REM_W) begin : g_wide
			always_comb begin
				if ($signed(rem_src) > $signed({{(TW-REM_W){1'b0}}, 32'h7FFF_FFFF})) begin
					rem_cl = 32'h7FFF_FFFF;
				end else if ($signed(rem_src) < $signed({{(TW-REM_W){1'b1}}, 32'h8000_0000})) begin
					rem_cl = 32'h8000_0000;
				end else begin
					rem_cl = rem_src[REM_W-1:0];
				end
			end
		end else begin : g_narrow
			assign rem_cl = REM_W'($signed(rem_src));
		end
	endgenerate

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_acc) begin
					unique case (in_func)
						FUNC_TICK:   state_d = ST_SCAN;
						FUNC_START,
						FUNC_CANCEL,
						FUNC_PAUSE,
						FUNC_RESUME,
						FUNC_QUERY:  state_d = ST_CMD;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				if (finish) state_d = ST_IDLE;
			end
			ST_CMD: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// fsm outputs
	always_comb begin
		cmd.ready = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = in_idx;
		wr_en     = 1'b0;
		wr_addr   = idx_s1;
		wr_data   = {scan_sum, per_rd};
		unique case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				rd_en     = cmd_acc;
			end
			ST_SCAN: begin
				rd_en   = adv && !iss_done;
				rd_addr = iss_q[IDX_W-1:0];
				wr_en   = fire && adv && rep_q[idx_s1];
			end
			ST_CMD: begin
				wr_en   = cmd_done && cok_q && c_wen;
				wr_addr = cidx;
				wr_data = {w_dl, w_per};
			end
			default: begin
			end
		endcase
	end

	// timer memory
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) mem_rd_q <= mem[rd_addr];
	end

	assign out_load = (fire && adv && pend_v_q) || drain || cmd_done;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			now_q    <= '0;
			act_q    <= '0;
			pau_q    <= '0;
			rep_q    <= '0;
			iss_q    <= '0;
			v_s1     <= 1'b0;
			cnt_q    <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd_acc && in_func == FUNC_TICK) begin
				now_q <= now_q + 1'b1;
				iss_q <= '0;
				v_s1  <= 1'b0;
				cnt_q <= '0;
			end
			if (state_q == ST_SCAN && adv) begin
				v_s1 <= !iss_done;
				if (!iss_done) iss_q <= iss_q + 1'b1;
			end
			if (fire && adv) begin
				cnt_q    <= cnt_q + 1'b1;
				pend_v_q <= 1'b1;
				if (!rep_q[idx_s1]) act_q[idx_s1] <= 1'b0;
			end else if (drain) begin
				pend_v_q <= 1'b0;
			end
			if (cmd_done && cok_q) begin
				act_q[cidx] <= act_n;
				pau_q[cidx] <= pau_n;
				rep_q[cidx] <= rep_n;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && adv) idx_s1 <= iss_q[IDX_W-1:0];
		if (fire && adv) begin
			pend_idx_q <= idx_s1;
			pend_run_q <= rep_q[idx_s1];
		end
		if (cmd_acc) begin
			cf_q   <= in_func;
			cid_q  <= cmd.timer_id;
			cdur_q <= TW'(cmd.duration_ms);
			crep_q <= cmd.repeat_mode;
			cok_q  <= in_ok;
		end
		if (cmd_done) begin
			out_kind_q <= (cf_q == FUNC_QUERY) ? KIND_QUERY : KIND_ACK;
			out_id_q   <= cid_q;
			out_rem_q  <= (cok_q && act_n) ? rem_cl : '0;
			out_run_q  <= cok_q && act_n;
			out_pau_q  <= cok_q && act_n && pau_n;
			out_last_q <= 1'b1;
		end else if ((fire && adv && pend_v_q) || drain) begin
			out_kind_q <= KIND_EXPIRED;
			out_id_q   <= pend_ext[ID_W-1:0];
			out_rem_q  <= '0;
			out_run_q  <= pend_run_q;
			out_pau_q  <= 1'b0;
			out_last_q <= drain;
		end
	end

	assign rsp.valid        = out_v_q;
	assign rsp.kind         = out_kind_q;
	assign rsp.which_timer  = out_id_q;
	assign rsp.remaining_ms = out_rem_q;
	assign rsp.is_running   = out_run_q;
	assign rsp.is_paused    = out_pau_q;
	assign rsp.last         = out_last_q;

	a_pause_needs_active: assert property (@(posedge clk) disable iff (!arst_n)
		(pau_q & ~act_q) == '0)
		else $error("paused flag set on an inactive timer");

	a_expiry_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RESULTS))
		else $error("expiry count above limit");

	a_pend_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> state_q == ST_SCAN)
		else $error("held expiry outside a scan");

	a_tick_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc && in_func == FUNC_TICK |=> state_q == ST_SCAN && iss_q == '0 && !v_s1)
		else $error("tick did not start a fresh scan");

endmodule

// ----- bench/tb_multi_channel_ms_timer_bank_top.sv -----
// ----------------------------------------------------------------------------
// tb_multi_channel_ms_timer_bank_top
// Self-checking bench for the millisecond timer bank. A fixed script of
// commands exercises the field extremes, every command and the corner cases.
// Random traffic follows in three flavors: general, expiry storms and noise.
// An in-bench model of the bank predicts every result item, and each item
// is compared field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_multi_channel_ms_timer_bank_top;

	import mctb_pkg::*;

	localparam int unsigned TIMERS      = NUM_TIMERS_DEF;
	localparam int          RANDOM_CMDS = 445;
	localparam int          QUIET_LIMIT = 3000;
	localparam int          SCRIPT_LEN  = 25;

	localparam logic [FUNC_W-1:0] FUNC_RSVD_A = 3'd6;
	localparam logic [FUNC_W-1:0] FUNC_RSVD_B = 3'd7;

	typedef enum int {MIX_GENERAL, MIX_STORM, MIX_NOISE} mix_t;
	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PATTERN} stall_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [ID_W-1:0]   id;
		logic [DUR_W-1:0]  dur;
		logic              rep;
		logic              typed;
		kind_t             kind;
		logic [REM_W-1:0]  rem;
		logic              run;
		logic              pau;
	} cmd_row_t;

	typedef struct packed {
		kind_t             kind;
		logic [ID_W-1:0]   timer;
		logic [REM_W-1:0]  rem;
		logic              run;
		logic              pau;
		logic              last;
	} timer_result_t;

	logic clk = 1'b0;
	logic arst_n;

	mctb_in_if  cmd_ch ();
	mctb_out_if rsp_ch ();

	multi_channel_ms_timer_bank_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// bank image kept by the bench
	logic [31:0]   ms_count;
	logic [31:0]   when_or_left [TIMERS];
	logic [31:0]   reload_ms [TIMERS];
	logic          armed [TIMERS];
	logic          held [TIMERS];
	logic          cyclic [TIMERS];

	timer_result_t bank_results [$];
	cmd_row_t      cur_row;
	int            fail_count = 0;
	int            quiet_cycles = 0;
	int            gap_left = 0;
	int            burst_left = 0;
	bit            calm = 1'b1;

	cmd_row_t script [SCRIPT_LEN] = '{
		'{FUNC_QUERY,  4'd0,  32'd0,          1'b0, 1'b1, KIND_QUERY, 32'd0,          1'b0, 1'b0},
		'{FUNC_QUERY,  4'd15, 32'd0,          1'b0, 1'b1, KIND_QUERY, 32'd0,          1'b0, 1'b0},
		'{FUNC_TICK,   4'd7,  32'd0,          1'b0, 1'b0, KIND_EXPIRED, 32'd0,        1'b0, 1'b0},
		'{FUNC_START,  4'd0,  32'd0,          1'b0, 1'b1, KIND_ACK,   32'd0,          1'b1, 1'b0},
		'{FUNC_START,  4'd15, 32'hFFFF_FFFF,  1'b1, 1'b1, KIND_ACK,   32'hFFFF_FFFF,  1'b1, 1'b0},
		'{FUNC_START,  4'd3,  32'h7FFF_FFFF,  1'b0, 1'b1, KIND_ACK,   32'h7FFF_FFFF,  1'b1, 1'b0},
		'{FUNC_START,  4'd4,  32'h8000_0000,  1'b1, 1'b1, KIND_ACK,   32'h8000_0000,  1'b1, 1'b0},
		'{FUNC_START,  4'd5,  32'd0,          1'b1, 1'b1, KIND_ACK,   32'd0,          1'b1, 1'b0},
		'{FUNC_TICK,   4'd0,  32'd0,          1'b0, 1'b0, KIND_EXPIRED, 32'd0,        1'b0, 1'b0},
		'{FUNC_PAUSE,  4'd3,  32'd0,          1'b0, 1'b0, KIND_EXPIRED, 32'd0,        1'b0, 1'b0},
		'{FUNC_PAUSE,  4'd3,  32'd0,          1'b0, 1'b0, KIND_EXPIRED, 32'd0,        1'b0, 1'b0},
		'{FUNC_TICK,   4'd0,  32'd0,          1'b0, 1'b0, KIND_EXPIRED, 32'd0,        1'b0, 1'b0},
		'{FUNC_RESUME, 4'd3,  32'd0,          1'b0, 1'b0, KIND_EXPIRED, 32'd0,        1'b0, 1'b0},
		'{FUNC_RESUME, 4'd3,  32'd0,          1'b0, 1'b0, KIND_EXPIRED, 32'd0,        1'b0, 1'b0},
		'{FUNC_PAUSE,  4'd9,  32'd0,          1'b0, 1'b1, KIND_ACK,   32'd0,          1'b0, 1'b0},
		'{FUNC_RESUME, 4'd9,  32'd0,          1'b0, 1'b1, KIND_ACK,   32'd0,          1'b0, 1'b0},
		'{FUNC_CANCEL, 4'd5,  32'd0,          1'b0, 1'b1, KIND_ACK,   32'd0,          1'b0, 1'b0},
		'{FUNC_RSVD_A, 4'd2,  32'h5555_5555,  1'b1, 1'b0, KIND_EXPIRED, 32'd0,        1'b0, 1'b0},
		'{FUNC_RSVD_B, 4'd10, 32'hAAAA_AAAA,  1'b0, 1'b0, KIND_EXPIRED, 32'd0,        1'b0, 1'b0},
		'{FUNC_START,  4'd10, 32'd3,          1'b1, 1'b0, KIND_EXPIRED, 32'd0,        1'b0, 1'b0},
		'{FUNC_TICK,   4'd0,  32'd0,          1'b0, 1'b0, KIND_EXPIRED, 32'd0,        1'b0, 1'b0},
		'{FUNC_TICK,   4'd0,  32'd0,          1'b0, 1'b0, KIND_EXPIRED, 32'd0,        1'b0, 1'b0},
		'{FUNC_QUERY,  4'd10, 32'd0,          1'b0, 1'b0, KIND_EXPIRED, 32'd0,        1'b0, 1'b0},
		'{FUNC_CANCEL, 4'd15, 32'd0,          1'b0, 1'b1, KIND_ACK,   32'd0,          1'b0, 1'b0},
		'{FUNC_QUERY,  4'd4,  32'd0,          1'b0, 1'b0, KIND_EXPIRED, 32'd0,        1'b0, 1'b0}
	};

	// apply one accepted command to the bank image and queue its results
	function automatic void bank_step(input cmd_row_t r);
		timer_result_t res;
		timer_result_t held_res;
		bit            have_res;
		int            t;
		int            n;
		if (r.func == FUNC_TICK) begin
			ms_count = ms_count + 32'd1;
			n = 0;
			have_res = 1'b0;
			for (t = 0; t < TIMERS && n < MAX_RESULTS; t++) begin
				if (armed[t] && !held[t] && !((ms_count - when_or_left[t]) >> 31)) begin
					if (cyclic[t]) begin
						when_or_left[t] = when_or_left[t] + reload_ms[t];
					end else begin
						armed[t] = 1'b0;
						when_or_left[t] = '0;
					end
					if (have_res)
						bank_results.push_back(held_res);
					held_res = '{KIND_EXPIRED, t[ID_W-1:0], 32'd0, armed[t], 1'b0, 1'b0};
					have_res = 1'b1;
					n++;
				end
			end
			if (have_res) begin
				held_res.last = 1'b1;
				bank_results.push_back(held_res);
			end
		end else if (r.func <= FUNC_QUERY) begin
			t = int'(r.id);
			case (r.func)
				FUNC_START: begin
					armed[t] = 1'b1;
					held[t] = 1'b0;
					cyclic[t] = r.rep;
					reload_ms[t] = r.dur;
					when_or_left[t] = ms_count + r.dur;
				end
				FUNC_CANCEL: begin
					armed[t] = 1'b0;
					held[t] = 1'b0;
					cyclic[t] = 1'b0;
					reload_ms[t] = '0;
					when_or_left[t] = '0;
				end
				FUNC_PAUSE: begin
					if (armed[t] && !held[t]) begin
						when_or_left[t] = when_or_left[t] - ms_count;
						held[t] = 1'b1;
					end
				end
				FUNC_RESUME: begin
					if (armed[t] && held[t]) begin
						when_or_left[t] = ms_count + when_or_left[t];
						held[t] = 1'b0;
					end
				end
				default: ;
			endcase
			res.kind = (r.func == FUNC_QUERY) ? KIND_QUERY : KIND_ACK;
			res.timer = r.id;
			res.rem = !armed[t] ? 32'd0 : held[t] ? when_or_left[t] : when_or_left[t] - ms_count;
			res.run = armed[t];
			res.pau = armed[t] && held[t];
			res.last = 1'b1;
			if (r.typed) begin
				res.kind = r.kind;
				res.rem = r.rem;
				res.run = r.run;
				res.pau = r.pau;
			end
			bank_results.push_back(res);
		end
	endfunction

	function automatic cmd_row_t make_row(input mix_t mix);
		cmd_row_t r;
		int       pick;
		r = '0;
		r.id = ID_W'($urandom_range(0, TIMERS - 1));
		r.rep = 1'($urandom_range(0, 1));
		r.dur = $urandom;
		pick = $urandom_range(0, 99);
		case (mix)
			MIX_NOISE: r.func = FUNC_W'($urandom_range(0, 7));
			MIX_STORM: begin
				if (pick < 50) begin
					r.func = FUNC_TICK;
				end else if (pick < 85) begin
					r.func = FUNC_START;
					r.dur = $urandom_range(0, 3);
					r.rep = (pick < 78);
				end else if (pick < 92) begin
					r.func = FUNC_PAUSE;
				end else if (pick < 96) begin
					r.func = FUNC_RESUME;
				end else begin
					r.func = FUNC_QUERY;
				end
			end
			default: begin
				if (pick < 35) begin
					r.func = FUNC_TICK;
				end else if (pick < 55) begin
					r.func = FUNC_START;
					if ($urandom_range(0, 7) != 0)
						r.dur = $urandom_range(0, 15);
				end else if (pick < 63) begin
					r.func = FUNC_CANCEL;
				end else if (pick < 75) begin
					r.func = FUNC_PAUSE;
				end else if (pick < 87) begin
					r.func = FUNC_RESUME;
				end else if (pick < 98) begin
					r.func = FUNC_QUERY;
				end else begin
					r.func = (pick == 98) ? FUNC_RSVD_A : FUNC_RSVD_B;
				end
			end
		endcase
		return r;
	endfunction

	task automatic send_cmd(input cmd_row_t r);
		@(negedge clk);
		while (gap_left > 0) begin
			cmd_ch.valid <= 1'b0;
			gap_left--;
			@(negedge clk);
		end
		cur_row = r;
		cmd_ch.valid <= 1'b1;
		cmd_ch.func <= r.func;
		cmd_ch.timer_id <= r.id;
		cmd_ch.duration_ms <= r.dur;
		cmd_ch.repeat_mode <= r.rep;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 24);
			if (calm)
				gap_left = 0;
			else if ($urandom_range(0, 4) == 0)
				gap_left = $urandom_range(4, 12);
			else
				gap_left = $urandom_range(0, 2);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_result();
		timer_result_t want;
		if (bank_results.size() == 0) begin
			$error("unexpected result item for timer %0d", rsp_ch.which_timer);
			fail_count++;
		end else begin
			want = bank_results.pop_front();
			check_field("kind", 32'(want.kind), 32'(rsp_ch.kind));
			check_field("which_timer", 32'(want.timer), 32'(rsp_ch.which_timer));
			check_field("remaining_ms", want.rem, rsp_ch.remaining_ms);
			check_field("is_running", 32'(want.run), 32'(rsp_ch.is_running));
			check_field("is_paused", 32'(want.pau), 32'(rsp_ch.is_paused));
			check_field("last", 32'(want.last), 32'(rsp_ch.last));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready)
				bank_step(cur_row);
			if (rsp_ch.valid && rsp_ch.ready)
				check_result();
			if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	initial begin : rsp_stall
		stall_t     style;
		int         span;
		logic [7:0] pat;
		rsp_ch.ready = 1'b0;
		forever begin
			style = stall_t'($urandom_range(0, 3));
			span = $urandom_range(16, 96);
			pat = 8'($urandom) | 8'h01;
			repeat (span) begin
				@(negedge clk);
				case (style)
					STALL_NONE:  rsp_ch.ready <= 1'b1;
					STALL_LIGHT: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
					STALL_HEAVY: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
					default: begin
						rsp_ch.ready <= pat[0];
						pat = {pat[0], pat[7:1]};
					end
				endcase
			end
		end
	end

	initial begin : watchdog
		while (quiet_cycles < QUIET_LIMIT)
			@(negedge clk);
		$display("[multi_channel_ms_timer_bank_top] ERROR");
		$finish;
	end

	initial begin : stimulus
		cmd_row_t r;
		mix_t     mix;
		int       sent;
		int       len;
		cmd_ch.valid = 1'b0;
		cmd_ch.func = FUNC_TICK;
		cmd_ch.timer_id = '0;
		cmd_ch.duration_ms = '0;
		cmd_ch.repeat_mode = 1'b0;
		cur_row = '0;
		ms_count = '0;
		for (int t = 0; t < TIMERS; t++) begin
			when_or_left[t] = '0;
			reload_ms[t] = '0;
			armed[t] = 1'b0;
			held[t] = 1'b0;
			cyclic[t] = 1'b0;
		end
		arst_n = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		foreach (script[k])
			send_cmd(script[k]);

		sent = 0;
		while (sent < RANDOM_CMDS) begin
			mix = mix_t'($urandom_range(0, 2));
			calm = ($urandom_range(0, 3) == 0);
			len = $urandom_range(15, 40);
			repeat (len) begin
				if (sent < RANDOM_CMDS) begin
					r = make_row(mix);
					send_cmd(r);
					sent++;
				end
			end
		end
		@(negedge clk);
		cmd_ch.valid <= 1'b0;

		while (bank_results.size() != 0)
			@(negedge clk);
		// a tick with nothing due may still be scanning
		repeat (TIMERS + 16) @(negedge clk);
		if (fail_count == 0)
			$display("[multi_channel_ms_timer_bank_top] OK");
		else
			$display("[multi_channel_ms_timer_bank_top] ERROR");
		$finish;
	end

endmodule
